// ===== src/slfcq_pkg.sv =====
// ----------------------------------------------------------------------------
// slfcq_pkg
// Shared types and constants of the serial line framer command queue.
// ----------------------------------------------------------------------------
package slfcq_pkg;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_F      = 8'h46;

  localparam logic [7:0] MAX_LINE_INDEX = 8'd165;

  localparam int QUEUE_DEPTH = 10;

  localparam int PEND_W = 4;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_PROMPT   = 3'd2,
    EV_EXECUTED = 3'd3,
    EV_EMPTY    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ON    = 2'd1,
    CLS_OFF   = 2'd2
  } cls_t;

  typedef enum logic [2:0] {
    M_EMPTY = 3'd0,
    M_O     = 3'd1,
    M_ON    = 3'd2,
    M_OF    = 3'd3,
    M_OFF   = 3'd4,
    M_OTHER = 3'd5
  } match_t;

  typedef enum logic [1:0] {
    CMD_CLOSE  = 2'd0,
    CMD_PROMPT = 2'd1,
    CMD_DRAIN  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    cls_t    cls;
  } cmd_t;

endpackage

// ===== src/slfcq_in_if.sv =====
// ----------------------------------------------------------------------------
// slfcq_in_if
// Input channel: received bytes and drain requests.
// ----------------------------------------------------------------------------
interface slfcq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink (input valid, kind, byte_value, output ready);
endinterface

// ===== src/slfcq_out_if.sv =====
// ----------------------------------------------------------------------------
// slfcq_out_if
// Result channel: line events and executed queue entries.
// ----------------------------------------------------------------------------
interface slfcq_out_if
  import slfcq_pkg::*;
;
  logic       valid;
  logic       ready;
  event_t     event_res;
  cls_t       line_class;
  logic       pin_level;
  logic [3:0] pending;
  logic       last;

  modport source (output valid, event_res, line_class, pin_level, pending, last,
                  input ready);
  modport sink (input valid, event_res, line_class, pin_level, pending, last,
                output ready);
endinterface

// ===== src/slfcq_front.sv =====
// ----------------------------------------------------------------------------
// slfcq_front
// Line framer: gathers bytes, tracks the ON / OFF match and issues commands.
// ----------------------------------------------------------------------------
module slfcq_front
  import slfcq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  slfcq_in_if.sink item,
  input  logic cmd_full,
  output logic cmd_push,
  output cmd_t cmd
);

  function automatic match_t match_next(match_t m, logic [7:0] b);
    match_t r;
    r = M_OTHER;
    if (m == M_EMPTY && b == CH_O) r = M_O;
    else if (m == M_O && b == CH_N) r = M_ON;
    else if (m == M_O && b == CH_F) r = M_OF;
    else if (m == M_OF && b == CH_F) r = M_OFF;
    return r;
  endfunction

  function automatic cls_t match_class(match_t m);
    cls_t r;
    r = CLS_OTHER;
    if (m == M_ON) r = CLS_ON;
    else if (m == M_OFF) r = CLS_OFF;
    return r;
  endfunction

  logic [7:0] line_length, line_length_next;
  logic [7:0] previous_byte, previous_byte_next;
  match_t     match_progress, match_progress_next;
  match_t     match_before_last, match_before_last_next;

  logic accept;
  logic crlf;
  logic [7:0] b;

  assign item.ready = !cmd_full;
  assign accept     = item.valid && item.ready;
  assign b          = item.byte_value;
  assign crlf       = (b == CH_LF) && (previous_byte == CH_CR);

  always_comb begin
    line_length_next       = line_length;
    previous_byte_next     = previous_byte;
    match_progress_next    = match_progress;
    match_before_last_next = match_before_last;
    cmd_push               = 1'b0;
    cmd.op                 = CMD_CLOSE;
    cmd.cls                = CLS_OTHER;
    if (accept) begin
      if (item.kind) begin
        cmd_push = 1'b1;
        cmd.op   = CMD_DRAIN;
      end else if (b != 8'd0) begin
        if (line_length != 8'd0 && b == CH_SPACE && previous_byte == CH_PROMPT) begin
          line_length_next       = 8'd0;
          previous_byte_next     = 8'd0;
          match_progress_next    = M_EMPTY;
          match_before_last_next = M_EMPTY;
          cmd_push               = 1'b1;
          cmd.op                 = CMD_PROMPT;
        end else if (line_length != 8'd0 && (crlf || line_length >= MAX_LINE_INDEX)) begin
          line_length_next       = 8'd0;
          previous_byte_next     = 8'd0;
          match_progress_next    = M_EMPTY;
          match_before_last_next = M_EMPTY;
          if (!(crlf && line_length == 8'd1)) begin
            cmd_push = 1'b1;
            cmd.op   = CMD_CLOSE;
            cmd.cls  = crlf ? match_class(match_before_last)
                            : match_class(match_next(match_progress, b));
          end
        end else begin
          match_before_last_next = match_progress;
          match_progress_next    = match_next(match_progress, b);
          previous_byte_next     = b;
          line_length_next       = line_length + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length       <= 8'd0;
      previous_byte     <= 8'd0;
      match_progress    <= M_EMPTY;
      match_before_last <= M_EMPTY;
    end else begin
      line_length       <= line_length_next;
      previous_byte     <= previous_byte_next;
      match_progress    <= match_progress_next;
      match_before_last <= match_before_last_next;
    end
  end

endmodule

// ===== src/slfcq_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// slfcq_cmd_queue
// Two-entry command queue between the framer and the executor.
// ----------------------------------------------------------------------------
module slfcq_cmd_queue
  import slfcq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/slfcq_back.sv =====
// ----------------------------------------------------------------------------
// slfcq_back
// Executor: class FIFO, pin driver and result register.
// ----------------------------------------------------------------------------
module slfcq_back
  import slfcq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  slfcq_out_if.source result
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_X    = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t           state, state_next;
  cls_t             mem [QUEUE_DEPTH];
  cls_t             rd_cls;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic             pin, pin_next;

  logic             ovalid;
  event_t           oev;
  cls_t             ocls;
  logic             opin;
  logic [PEND_W-1:0] opend;
  logic             olast;

  logic             out_free;
  logic             load;
  event_t           l_ev;
  cls_t             l_cls;
  logic             l_last;
  logic             mem_we;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_inc;

  assign out_free = !ovalid || result.ready;
  assign tail_sum = {1'b0, head} + (PTR_W + 1)'(count);
  assign tail     = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : tail_sum[PTR_W-1:0];
  assign head_inc = (head == LAST_PTR) ? '0 : head + PTR_W'(1);

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    pin_next   = pin;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    l_ev       = EV_QUEUED;
    l_cls      = CLS_OTHER;
    l_last     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            CMD_CLOSE: begin
              load  = 1'b1;
              l_cls = cmd.cls;
              if (count >= FULL_COUNT) begin
                l_ev = EV_DROPPED;
              end else begin
                l_ev       = EV_QUEUED;
                mem_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PROMPT: begin
              load = 1'b1;
              l_ev = EV_PROMPT;
            end
            CMD_DRAIN: begin
              if (count == '0) begin
                load = 1'b1;
                l_ev = EV_EMPTY;
              end else begin
                state_next = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          load       = 1'b1;
          l_ev       = EV_EXECUTED;
          l_cls      = rd_cls;
          l_last     = (count == CNT_W'(1));
          count_next = count - CNT_W'(1);
          head_next  = head_inc;
          if (rd_cls == CLS_ON) pin_next = 1'b1;
          else if (rd_cls == CLS_OFF) pin_next = 1'b0;
          state_next = (count == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cmd.cls;
    end
    rd_cls <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oev   <= l_ev;
      ocls  <= l_cls;
      opin  <= pin_next;
      opend <= PEND_W'(count_next);
      olast <= l_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      count  <= '0;
      pin    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pin   <= pin_next;
      if (load) ovalid <= 1'b1;
      else if (result.ready) ovalid <= 1'b0;
    end
  end

  assign result.valid      = ovalid;
  assign result.event_res  = oev;
  assign result.line_class = ocls;
  assign result.pin_level  = opin;
  assign result.pending    = opend;
  assign result.last       = olast;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("class fifo count above depth");

  a_exec_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH || state == ST_EXEC) |-> count != '0)
    else $error("drain walking an empty fifo");

  a_pin_only_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(pin))
    else $error("pin changed outside execution");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_free) |=> ovalid && oev == EV_EXECUTED)
    else $error("executed entry without result");

endmodule

// ===== src/serial_line_framer_command_queue.sv =====
// ----------------------------------------------------------------------------
// serial_line_framer_command_queue
// Serial line framer with an ON / OFF command queue driving one pin.
// ----------------------------------------------------------------------------
// A received byte item is taken when the command queue has room; a byte that
// closes a non-empty line or ends it at a prompt gives one result, which passes
// the command queue and is registered by the executor when it is idle. A drain
// item is dispatched from idle and then walks the class FIFO in two states per
// queued entry (FETCH reads the FIFO memory, EXEC executes and registers the
// result, waiting while the result register is busy). The framer and the
// executor are parted by a two-entry command queue; item ready drops only while that queue is full.
module serial_line_framer_command_queue
  import slfcq_pkg::*;
(
  input logic clk,
  input logic rst,
  slfcq_in_if.sink item,
  slfcq_out_if.source result
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  slfcq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  slfcq_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (cmd_full),
    .valid    (cmd_valid),
    .head_cmd (cmd_head),
    .pop      (cmd_pop)
  );

  slfcq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .result    (result)
  );

endmodule

// ===== tb/sv/serial_line_framer_command_queue_checker.sv =====
// ----------------------------------------------------------------------------
// serial_line_framer_command_queue_checker
// Watches the item and result channels of the line framer. It keeps its own
// copy of the line state, the class FIFO and the pin, works out the results
// of every accepted item and compares each accepted result field by field
// with the oldest one still due. Mismatches are counted for the testbench.
// ----------------------------------------------------------------------------
module serial_line_framer_command_queue_checker
  import slfcq_pkg::*;
(
  input logic clk,
  input logic rst,
  slfcq_in_if item,
  slfcq_out_if result,
  output int errors,
  output int outstanding
);

  typedef struct packed {
    event_t     ev;
    cls_t       cls;
    logic       pin;
    logic [3:0] pend;
    logic       last;
  } line_result_t;

  logic [7:0]   line_len;
  logic [7:0]   prev_byte;
  match_t       cur_match;
  match_t       prior_match;
  cls_t         class_q [QUEUE_DEPTH];
  int unsigned  head;
  int unsigned  count;
  logic         pin;
  line_result_t due_results[$];

  function automatic match_t advance_match(match_t m, logic [7:0] b);
    if (m == M_EMPTY && b == CH_O) return M_O;
    if (m == M_O && b == CH_N) return M_ON;
    if (m == M_O && b == CH_F) return M_OF;
    if (m == M_OF && b == CH_F) return M_OFF;
    return M_OTHER;
  endfunction

  function automatic cls_t class_of(match_t m);
    if (m == M_ON) return CLS_ON;
    if (m == M_OFF) return CLS_OFF;
    return CLS_OTHER;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic clear_line();
    line_len = '0;
    prev_byte = '0;
    cur_match = M_EMPTY;
    prior_match = M_EMPTY;
  endtask

  task automatic store_byte(input logic [7:0] b);
    prior_match = cur_match;
    cur_match = advance_match(cur_match, b);
    prev_byte = b;
    line_len = line_len + 8'd1;
  endtask

  task automatic note_result(input event_t ev, input cls_t c, input logic lst);
    due_results.push_back('{ev, c, pin, 4'(count), lst});
  endtask

  task automatic track_item(input logic k, input logic [7:0] b);
    bit   crlf;
    cls_t c;
    if (k) begin
      if (count == 0) begin
        note_result(EV_EMPTY, CLS_OTHER, 1'b1);
      end else begin
        while (count > 0) begin
          c = class_q[head];
          if (c == CLS_ON) pin = 1'b1;
          else if (c == CLS_OFF) pin = 1'b0;
          head = (head + 1) % QUEUE_DEPTH;
          count--;
          note_result(EV_EXECUTED, c, count == 0);
        end
      end
    end else if (b != 8'h00) begin
      crlf = (b == CH_LF && prev_byte == CH_CR);
      if (line_len == 0) begin
        store_byte(b);
      end else if (b == CH_SPACE && prev_byte == CH_PROMPT) begin
        clear_line();
        note_result(EV_PROMPT, CLS_OTHER, 1'b1);
      end else if (crlf && line_len == 1) begin
        clear_line();
      end else if (crlf || line_len >= MAX_LINE_INDEX) begin
        // the CR of a CR LF close is not part of the line
        c = crlf ? class_of(prior_match) : class_of(advance_match(cur_match, b));
        clear_line();
        if (count >= QUEUE_DEPTH) begin
          note_result(EV_DROPPED, c, 1'b1);
        end else begin
          class_q[(head + count) % QUEUE_DEPTH] = c;
          count++;
          note_result(EV_QUEUED, c, 1'b1);
        end
      end else begin
        store_byte(b);
      end
    end
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      clear_line();
      head = 0;
      count = 0;
      pin = 1'b0;
      errors = 0;
      due_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing due, event_res %0d",
                                    result.event_res));
        end else begin
          want = due_results.pop_front();
          if (result.event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, expected %0d",
                                      result.event_res, want.ev));
          if (result.line_class !== want.cls)
            report_mismatch($sformatf("line_class %0d, expected %0d",
                                      result.line_class, want.cls));
          if (result.pin_level !== want.pin)
            report_mismatch($sformatf("pin_level %0d, expected %0d",
                                      result.pin_level, want.pin));
          if (result.pending !== want.pend)
            report_mismatch($sformatf("pending %0d, expected %0d",
                                      result.pending, want.pend));
          if (result.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d",
                                      result.last, want.last));
        end
      end
      if (item.valid && item.ready) track_item(item.kind, item.byte_value);
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== tb/sv/serial_line_framer_command_queue_tb.sv =====
// ----------------------------------------------------------------------------
// serial_line_framer_command_queue_tb
// Drives bytes and drain requests into the line framer: a directed opening
// with ON, OFF, other, prompt, empty and zero-byte lines, a queue overflow,
// a maximum-length line, then random command lines, noise and drains.
// Both channels stall at random; a checker beside the block scores results.
// ----------------------------------------------------------------------------
module serial_line_framer_command_queue_tb;
  import slfcq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 60;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int   idle_cycles = 0;
  int   items_sent = 0;
  int   errors;
  int   outstanding;

  slfcq_in_if item ();
  slfcq_out_if result ();

  serial_line_framer_command_queue dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result)
  );

  serial_line_framer_command_queue_checker line_check (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .errors(errors),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    result.ready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic k, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 11) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid <= 1'b1;
    item.kind <= k;
    item.byte_value <= b;
    do @(posedge clk); while (!item.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(1'b0, b);
  endtask

  task automatic drain();
    send(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_letters(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(8'h61, 8'h7A)));
  endtask

  task automatic send_command_line();
    string words [8];
    string w;
    words = '{"ON", "OFF", "O", "OF", "OFFF", "ONO", "NO", "OFN"};
    w = words[$urandom_range(0, 7)];
    for (int i = 0; i < w.len(); i++) begin
      if ($urandom_range(0, 99) < 20) send_byte(8'h00);
      send_byte(w[i]);
    end
    send_byte(CH_CR);
    if ($urandom_range(0, 99) < 90) send_byte(CH_LF);
    else send_byte(8'($urandom_range(1, 255)));
  endtask

  initial begin
    int pick;
    int random_start;
    item.valid = 1'b0;
    item.kind = 1'b0;
    item.byte_value = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening
    drain();
    send_line("ON");
    send_line("OFF");
    send_byte(8'h00);
    send_byte(CH_PROMPT);
    send_byte(CH_SPACE);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_O);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    drain();
    send_line("ON");
    drain();

    // overflow of the class queue, then the length limit
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
      if (i % 2) send_line("OFF");
      else send_line("ON");
    end
    drain();
    send_letters(MAX_LINE_INDEX + 1);
    send_text(" ON");
    send_byte(CH_CR);
    send_byte(CH_LF);
    drain();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      steady <= (items_sent - random_start >= 20) && (items_sent - random_start < 40);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        drain();
      end else if (pick < 40) begin
        send_command_line();
      end else if (pick < 55) begin
        for (int i = $urandom_range(1, 8); i > 0; i--)
          send_byte(8'($urandom_range(1, 255)));
        send_byte(CH_CR);
        send_byte(CH_LF);
      end else if (pick < 65) begin
        send_letters($urandom_range(0, 3));
        send_byte(CH_PROMPT);
        send_byte(CH_SPACE);
      end else if (pick < 72) begin
        if ($urandom_range(0, 1)) send_byte(CH_CR);
        send_byte(CH_LF);
      end else if (pick < 80) begin
        for (int i = 0; i < 4; i++) begin
          if ($urandom_range(0, 1)) send_line("OFF");
          else send_line("ON");
        end
      end else begin
        for (int i = $urandom_range(1, 4); i > 0; i--)
          send_byte(8'($urandom_range(0, 255)));
      end
    end
    drain();
    item.valid <= 1'b0;
    steady <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
